[rtl/core/pflm_pkg.sv]
// Shared types and constants for the per-flow latency/jitter/loss monitor.
// Used by pflm_ctrl, pflm_datapath and the top level; depends on nothing.
`default_nettype none

package pflm_pkg;

    // Field widths fixed by the arrival and result formats
    localparam int unsigned FLOW_W     = 4;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned CNT_W      = 48;
    localparam int unsigned LAT_W      = 49;
    localparam int unsigned DIFF_W     = 50;
    localparam int unsigned LSUM_W     = 64;
    localparam int unsigned JSUM_W     = 63;
    localparam int unsigned JIT_W      = 49;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 1'b1;

    // Saturation limits
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [JSUM_W-1:0] JSUM_MAX = {JSUM_W{1'b1}};
    localparam logic [LSUM_W-1:0] LSUM_MAX = {1'b0, {(LSUM_W-1){1'b1}}};
    localparam logic [LSUM_W-1:0] LSUM_MIN = {1'b1, {(LSUM_W-1){1'b0}}};

    // Controller sequence: an arrival that counts walks through these states in order
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ACCUM,
        S_JIT,
        S_COMMIT
    } state_t;

    // Per-flow table entry (seen flag lives in flops beside the table)
    typedef struct packed {
        logic [SEQ_W-1:0]  prev_seq;
        logic [CNT_W-1:0]  recv_cnt;
        logic [CNT_W-1:0]  loss_cnt;
        logic [LSUM_W-1:0] lat_sum;
        logic [CNT_W-1:0]  lat_max;
        logic [JSUM_W-1:0] jit_sum;
        logic [JIT_W-1:0]  jit_max;
        logic [LAT_W-1:0]  prev_lat;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic accum;
        logic jit;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic drop;
    } status_t;

endpackage

`default_nettype wire

[rtl/core/pflm_ctrl.sv]
// Controller for the flow monitor: sequences one arrival through the
// read-modify-write of the flow table and owns the result valid flag.
// Depends on pflm_pkg.
`default_nettype none

module pflm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire pflm_pkg::status_t status,
    output pflm_pkg::cmd_t        cmd
);

    pflm_pkg::state_t state_reg;
    pflm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // Output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pflm_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = pflm_pkg::S_CHECK;
            end
            pflm_pkg::S_CHECK:
            begin
                if (status.drop)
                    state_next = pflm_pkg::S_IDLE;
                else
                    state_next = pflm_pkg::S_ACCUM;
            end
            pflm_pkg::S_ACCUM:  state_next = pflm_pkg::S_JIT;
            pflm_pkg::S_JIT:    state_next = pflm_pkg::S_COMMIT;
            pflm_pkg::S_COMMIT:
            begin
                if (out_free)
                    state_next = pflm_pkg::S_IDLE;
            end
            default:            state_next = pflm_pkg::S_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        in_ready   = (state_reg == pflm_pkg::S_IDLE);
        cmd.load   = in_ready && in_valid;
        cmd.check  = (state_reg == pflm_pkg::S_CHECK);
        cmd.accum  = (state_reg == pflm_pkg::S_ACCUM);
        cmd.jit    = (state_reg == pflm_pkg::S_JIT);
        cmd.commit = (state_reg == pflm_pkg::S_COMMIT) && out_free;
    end

    // Result valid: set on commit, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pflm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pflm_datapath.sv]
// Datapath for the flow monitor: configuration registers, per-flow table
// memory with seen flags, staged statistic updates and result registers.
// Depends on pflm_pkg.
`default_nettype none

module pflm_datapath #(
    parameter int unsigned NUM_FLOWS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_valid,
    input  wire logic [pflm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pflm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // arrival
    input  wire logic [pflm_pkg::FLOW_W-1:0]         flow_id,
    input  wire logic [pflm_pkg::SEQ_W-1:0]          seq_num,
    input  wire logic [pflm_pkg::TIME_W-1:0]         send_time_ns,
    input  wire logic [pflm_pkg::TIME_W-1:0]         recv_time_ns,
    // control
    input  wire pflm_pkg::cmd_t                      cmd,
    output pflm_pkg::status_t                        status,
    // result
    output logic [pflm_pkg::FLOW_W-1:0]              flow_out,
    output logic [pflm_pkg::CNT_W-1:0]               received_count,
    output logic [pflm_pkg::CNT_W-1:0]               lost_count,
    output logic [pflm_pkg::LAT_W-1:0]               latency_ns,
    output logic [pflm_pkg::JIT_W-1:0]               jitter_ns,
    output logic [pflm_pkg::LSUM_W-1:0]              latency_total,
    output logic [pflm_pkg::CNT_W-1:0]               latency_peak,
    output logic [pflm_pkg::JSUM_W-1:0]              jitter_total,
    output logic [pflm_pkg::JIT_W-1:0]               jitter_peak
);

    // Only flows that fit the flow field can ever be addressed
    localparam int unsigned FLOW_SPACE = 2 ** pflm_pkg::FLOW_W;
    localparam int unsigned DEPTH      = (NUM_FLOWS < FLOW_SPACE) ? NUM_FLOWS : FLOW_SPACE;
    localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration
    logic                             enable_reg;
    logic [pflm_pkg::TIME_W-1:0]      start_time_reg;

    // Flow table
    pflm_pkg::entry_t                 mem [DEPTH];
    logic [DEPTH-1:0]                 seen_reg;

    // Captured arrival and table read
    logic [pflm_pkg::FLOW_W-1:0]      flow_reg;
    logic [pflm_pkg::SEQ_W-1:0]       seq_reg;
    logic [pflm_pkg::TIME_W-1:0]      send_reg;
    logic [pflm_pkg::TIME_W-1:0]      recv_reg;
    pflm_pkg::entry_t                 rd_reg;
    logic                             was_seen_reg;
    pflm_pkg::entry_t                 ent;
    logic [IDX_W-1:0]                 in_idx;
    logic [IDX_W-1:0]                 cur_idx;

    // Stage registers
    logic [pflm_pkg::LAT_W-1:0]       lat_reg;
    logic [pflm_pkg::LAT_W-1:0]       lat_next;
    logic [pflm_pkg::SEQ_W-1:0]       gap_reg;
    logic [pflm_pkg::SEQ_W-1:0]       gap_next;
    logic [pflm_pkg::SEQ_W-1:0]       expected;
    logic                             gap_en_reg;
    logic                             gap_en_next;

    logic [pflm_pkg::CNT_W-1:0]       recv_cnt_reg;
    logic [pflm_pkg::CNT_W-1:0]       recv_cnt_next;
    logic [pflm_pkg::CNT_W-1:0]       loss_reg;
    logic [pflm_pkg::CNT_W-1:0]       loss_next;
    logic [pflm_pkg::CNT_W:0]         loss_sum;
    logic [pflm_pkg::LSUM_W-1:0]      lat_sum_reg;
    logic [pflm_pkg::LSUM_W-1:0]      lat_sum_next;
    logic [pflm_pkg::LSUM_W-1:0]      lat_ext;
    logic [pflm_pkg::LSUM_W-1:0]      lat_raw;
    logic [pflm_pkg::CNT_W-1:0]       lat_max_reg;
    logic [pflm_pkg::CNT_W-1:0]       lat_max_next;
    logic [pflm_pkg::DIFF_W-1:0]      diff_reg;
    logic [pflm_pkg::DIFF_W-1:0]      diff_next;

    logic [pflm_pkg::JIT_W-1:0]       jit_reg;
    logic [pflm_pkg::JIT_W-1:0]       jit_next;
    logic [pflm_pkg::DIFF_W-1:0]      diff_abs;

    logic [pflm_pkg::JSUM_W:0]        jit_sum_raw;
    logic [pflm_pkg::JSUM_W-1:0]      jit_sum_next;
    logic [pflm_pkg::JIT_W-1:0]       jit_max_next;
    pflm_pkg::entry_t                 wr_entry;

    // Configuration writes; the port never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            start_time_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pflm_pkg::CFG_ENABLE:     enable_reg     <= cfg_data[0];
                pflm_pkg::CFG_START_TIME: start_time_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign in_idx  = flow_id[IDX_W-1:0];
    assign cur_idx = flow_reg[IDX_W-1:0];

    // Table write on commit, registered read on accept
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            mem[cur_idx] <= wr_entry;
        if (cmd.load)
            rd_reg <= mem[in_idx];
    end

    // Seen flags stand in for clearing the table: unseen reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (cmd.commit)
            seen_reg[cur_idx] <= 1'b1;
    end

    // Capture the arrival
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            flow_reg     <= flow_id;
            seq_reg      <= seq_num;
            send_reg     <= send_time_ns;
            recv_reg     <= recv_time_ns;
            was_seen_reg <= seen_reg[in_idx];
        end
    end

    assign ent = was_seen_reg ? rd_reg : '0;

    // Drop: disabled, early, or flow outside the table
    assign status.drop = !enable_reg || (recv_reg < start_time_reg) ||
                         ({{(32 - pflm_pkg::FLOW_W){1'b0}}, flow_reg} >= 32'(NUM_FLOWS));

    // Check stage: latency and sequence gap
    always_comb
    begin
        lat_next    = {1'b0, recv_reg} - {1'b0, send_reg};
        expected    = ent.prev_seq + 1'b1;
        gap_next    = seq_reg - expected;
        gap_en_next = was_seen_reg && (seq_reg > expected);
    end

    // Accumulate stage: counters, latency sum and peak, latency change
    always_comb
    begin
        recv_cnt_next = (ent.recv_cnt == pflm_pkg::CNT_MAX) ? ent.recv_cnt
                                                            : ent.recv_cnt + 1'b1;

        loss_sum  = {1'b0, ent.loss_cnt} + {{(pflm_pkg::CNT_W + 1 - pflm_pkg::SEQ_W){1'b0}}, gap_reg};
        loss_next = ent.loss_cnt;
        if (gap_en_reg)
            loss_next = loss_sum[pflm_pkg::CNT_W] ? pflm_pkg::CNT_MAX
                                                  : loss_sum[pflm_pkg::CNT_W-1:0];

        // signed saturating add
        lat_ext      = {{(pflm_pkg::LSUM_W - pflm_pkg::LAT_W){lat_reg[pflm_pkg::LAT_W-1]}}, lat_reg};
        lat_raw      = ent.lat_sum + lat_ext;
        lat_sum_next = lat_raw;
        if ((ent.lat_sum[pflm_pkg::LSUM_W-1] == lat_ext[pflm_pkg::LSUM_W-1]) &&
            (lat_raw[pflm_pkg::LSUM_W-1] != ent.lat_sum[pflm_pkg::LSUM_W-1]))
            lat_sum_next = ent.lat_sum[pflm_pkg::LSUM_W-1] ? pflm_pkg::LSUM_MIN
                                                           : pflm_pkg::LSUM_MAX;

        // negative latencies never raise the peak
        lat_max_next = ent.lat_max;
        if (!lat_reg[pflm_pkg::LAT_W-1] && (lat_reg[pflm_pkg::CNT_W-1:0] > ent.lat_max))
            lat_max_next = lat_reg[pflm_pkg::CNT_W-1:0];

        diff_next = {lat_reg[pflm_pkg::LAT_W-1], lat_reg} -
                    {ent.prev_lat[pflm_pkg::LAT_W-1], ent.prev_lat};
    end

    // Jitter stage: magnitude of latency change, zero on first arrival
    always_comb
    begin
        diff_abs = diff_reg[pflm_pkg::DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
        jit_next = was_seen_reg ? diff_abs[pflm_pkg::JIT_W-1:0] : '0;
    end

    // Commit stage: jitter sum and peak, new table entry
    always_comb
    begin
        jit_sum_raw  = {1'b0, ent.jit_sum} + {{(pflm_pkg::JSUM_W + 1 - pflm_pkg::JIT_W){1'b0}}, jit_reg};
        jit_sum_next = ent.jit_sum;
        jit_max_next = ent.jit_max;
        if (was_seen_reg)
        begin
            jit_sum_next = jit_sum_raw[pflm_pkg::JSUM_W] ? pflm_pkg::JSUM_MAX
                                                         : jit_sum_raw[pflm_pkg::JSUM_W-1:0];
            if (jit_reg > ent.jit_max)
                jit_max_next = jit_reg;
        end

        wr_entry.prev_seq = seq_reg;
        wr_entry.recv_cnt = recv_cnt_reg;
        wr_entry.loss_cnt = loss_reg;
        wr_entry.lat_sum  = lat_sum_reg;
        wr_entry.lat_max  = lat_max_reg;
        wr_entry.jit_sum  = jit_sum_next;
        wr_entry.jit_max  = jit_max_next;
        wr_entry.prev_lat = lat_reg;
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            lat_reg    <= lat_next;
            gap_reg    <= gap_next;
            gap_en_reg <= gap_en_next;
        end
        if (cmd.accum)
        begin
            recv_cnt_reg <= recv_cnt_next;
            loss_reg     <= loss_next;
            lat_sum_reg  <= lat_sum_next;
            lat_max_reg  <= lat_max_next;
            diff_reg     <= diff_next;
        end
        if (cmd.jit)
            jit_reg <= jit_next;
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            flow_out       <= flow_reg;
            received_count <= recv_cnt_reg;
            lost_count     <= loss_reg;
            latency_ns     <= lat_reg;
            jitter_ns      <= jit_reg;
            latency_total  <= lat_sum_reg;
            latency_peak   <= lat_max_reg;
            jitter_total   <= jit_sum_next;
            jitter_peak    <= jit_max_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/per_flow_latency_jitter_loss_monitor.sv]
// Top level of the per-flow latency, jitter and sequence-loss monitor.
// Instantiates pflm_ctrl and pflm_datapath; depends on pflm_pkg.
`default_nettype none

// One arrival is handled at a time. An accepted arrival that counts gives
// its flow's updated statistics through the check, accumulate, jitter and
// commit states, and the next arrival is taken in the cycle after commit;
// no new arrival is taken before the last one is through the controller's
// read-modify-write sequence over the single-port flow table. An arrival
// that is dropped (block disabled, receive time before the start time, flow
// number not below NUM_FLOWS) gives no result and returns to idle after
// the check state. Commit waits while the result register still holds an
// untaken result; a waiting result does not block acceptance. The flow
// table needs no clearing pass: per-flow seen flags reset to zero and an
// unseen flow reads as all zero. cfg_ready is always high; write
// configuration only while no arrival is in flight.
module per_flow_latency_jitter_loss_monitor #(
    parameter int unsigned NUM_FLOWS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pflm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pflm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // arrival channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [pflm_pkg::FLOW_W-1:0]         flow_id,
    input  wire logic [pflm_pkg::SEQ_W-1:0]          seq_num,
    input  wire logic [pflm_pkg::TIME_W-1:0]         send_time_ns,
    input  wire logic [pflm_pkg::TIME_W-1:0]         recv_time_ns,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [pflm_pkg::FLOW_W-1:0]              flow_out,
    output logic [pflm_pkg::CNT_W-1:0]               received_count,
    output logic [pflm_pkg::CNT_W-1:0]               lost_count,
    output logic signed [pflm_pkg::LAT_W-1:0]        latency_ns,
    output logic [pflm_pkg::JIT_W-1:0]               jitter_ns,
    output logic signed [pflm_pkg::LSUM_W-1:0]       latency_total,
    output logic [pflm_pkg::CNT_W-1:0]               latency_peak,
    output logic [pflm_pkg::JSUM_W-1:0]              jitter_total,
    output logic [pflm_pkg::JIT_W-1:0]               jitter_peak
);

    pflm_pkg::cmd_t    cmd;
    pflm_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pflm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pflm_datapath #(
        .NUM_FLOWS (NUM_FLOWS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .flow_id        (flow_id),
        .seq_num        (seq_num),
        .send_time_ns   (send_time_ns),
        .recv_time_ns   (recv_time_ns),
        .cmd            (cmd),
        .status         (status),
        .flow_out       (flow_out),
        .received_count (received_count),
        .lost_count     (lost_count),
        .latency_ns     (latency_ns),
        .jitter_ns      (jitter_ns),
        .latency_total  (latency_total),
        .latency_peak   (latency_peak),
        .jitter_total   (jitter_total),
        .jitter_peak    (jitter_peak)
    );

`ifndef SYNTHESIS
    // only one arrival in flight: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("arrival accepted while another is in flight");

    // a commit always presents a result in the next cycle
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result register overwritten before transfer");
`endif

endmodule

`default_nettype wire
